// ----- hw/rtl/sdf_pkg.sv -----
`default_nettype none
package sdf_pkg;

  localparam int VALUE_W = 64;
  localparam int DIGITS  = 19;
  localparam int BCD_W   = 4 * DIGITS;
  localparam int BITCNT_W = $clog2(VALUE_W);
  localparam int DIGCNT_W = $clog2(DIGITS + 1);

  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_MINUS = 8'd45;
  localparam logic [7:0] ASCII_NINE  = 8'd57;

  localparam logic [BITCNT_W-1:0] BIT_LAST  = BITCNT_W'(VALUE_W - 1);
  localparam logic [DIGCNT_W-1:0] DIG_START = DIGCNT_W'(DIGITS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_EMIT
  } sdf_state_t;

  typedef logic [BCD_W-1:0] bcd_t;

endpackage
`default_nettype wire

// ----- hw/rtl/sdf_dabble_step.sv -----
`default_nettype none
module sdf_dabble_step
  import sdf_pkg::*;
(
  input  wire bcd_t bcd_in,
  input  wire logic bit_in,
  output bcd_t      bcd_out
);

  bcd_t adjusted;

  // Each digit that is five or more gets three added before the shift, so
  // the doubling carries into the next digit as a decimal carry.
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd_in[4*i +: 4] >= 4'd5) begin
        adjusted[4*i +: 4] = bcd_in[4*i +: 4] + 4'd3;
      end else begin
        adjusted[4*i +: 4] = bcd_in[4*i +: 4];
      end
    end
  end

  assign bcd_out = {adjusted[BCD_W-2:0], bit_in};

endmodule
`default_nettype wire

// ----- hw/rtl/signed_decimal_formatter_top.sv -----
`default_nettype none
// Channel   | Signals                          | Payload
// ----------+----------------------------------+----------------------------
// input     | value_valid / value_ready        | value[63:0], signed
// output    | char_valid / char_ready          | character[7:0], last
//
// A request is taken only in the idle state. The magnitude then goes through
// the shift-add-3 unit one bit per cycle, and the digit register is scanned
// one digit per cycle while the output is not stalled, after a leading minus
// sign for a negative value. Leading zeros are dropped in that scan, and an
// output stall holds the scan.
// Reset is synchronous and clears the sequencer and the output valid.
module signed_decimal_formatter_top
  import sdf_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               value_valid,
  output logic                    value_ready,
  input  wire logic [VALUE_W-1:0] value,
  output logic                    char_valid,
  input  wire logic               char_ready,
  output logic [7:0]              character,
  output logic                    last
);

  sdf_state_t state, state_next;

  logic [VALUE_W-1:0]  mag;
  bcd_t                bcd;
  bcd_t                bcd_step;
  logic [BITCNT_W-1:0] bit_cnt;
  logic [DIGCNT_W-1:0] dig_cnt;
  logic                neg_pend;
  logic                started;

  logic                in_take;
  logic                out_free;
  logic                emit_take;
  logic                emit_load;
  logic [3:0]          top_digit;

  assign top_digit = bcd[BCD_W-1 -: 4];

  sdf_dabble_step u_step (
    .bcd_in  (bcd),
    .bit_in  (mag[VALUE_W-1]),
    .bcd_out (bcd_step)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (value_valid) state_next = ST_CONVERT;
      end
      ST_CONVERT: begin
        if (bit_cnt == BIT_LAST) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_take && !neg_pend && dig_cnt == DIGCNT_W'(1)) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    value_ready = (state == ST_IDLE);
    in_take     = value_ready && value_valid;
    out_free    = !char_valid || char_ready;
    emit_take   = (state == ST_EMIT) && out_free;
    // A leading zero is dropped without a result unless it is the only digit.
    emit_load   = emit_take &&
                  (neg_pend || started || top_digit != 4'd0 || dig_cnt == DIGCNT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      char_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit_load) begin
        char_valid <= 1'b1;
      end else if (char_ready) begin
        char_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      mag      <= value[VALUE_W-1] ? (~value + VALUE_W'(1)) : value;
      bcd      <= '0;
      bit_cnt  <= '0;
      dig_cnt  <= DIG_START;
      neg_pend <= value[VALUE_W-1];
      started  <= 1'b0;
    end else if (state == ST_CONVERT) begin
      mag     <= {mag[VALUE_W-2:0], 1'b0};
      bcd     <= bcd_step;
      bit_cnt <= bit_cnt + BITCNT_W'(1);
    end else if (emit_take) begin
      if (neg_pend) begin
        neg_pend <= 1'b0;
      end else begin
        bcd     <= {bcd[BCD_W-5:0], 4'd0};
        dig_cnt <= dig_cnt - DIGCNT_W'(1);
        if (emit_load) started <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      if (neg_pend) begin
        character <= ASCII_MINUS;
        last      <= 1'b0;
      end else begin
        character <= ASCII_ZERO + {4'd0, top_digit};
        last      <= (dig_cnt == DIGCNT_W'(1));
      end
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    value_valid && value_ready |=> state == ST_CONVERT && bit_cnt == '0)
    else $error("accepted request did not start the conversion");

  a_convert_count: assert property (@(posedge clk) disable iff (rst)
    state == ST_CONVERT && bit_cnt != BIT_LAST |=>
      state == ST_CONVERT && bit_cnt == $past(bit_cnt) + BITCNT_W'(1))
    else $error("conversion counter skipped or left early");

  a_char_legal: assert property (@(posedge clk) disable iff (rst)
    char_valid |-> character == ASCII_MINUS ||
                   (character >= ASCII_ZERO && character <= ASCII_NINE))
    else $error("output character is neither a digit nor a minus sign");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    char_valid && character == ASCII_MINUS |-> !last)
    else $error("minus sign flagged as the final character");

  a_emit_done_free: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> dig_cnt != '0)
    else $error("digit scan ran past the final digit");

endmodule
`default_nettype wire
